### design/rgbpk_pkg.sv
package rgbpk_pkg;

   localparam logic KindPack   = 1'b0;
   localparam logic KindUnpack = 1'b1;

   localparam logic [31:0] SingleInf = 32'h7F80_0000;
   localparam logic [31:0] SingleNan = 32'h7FC0_0000;

   typedef struct packed {
      logic [31:0] packed_word;
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
   } result_type;

endpackage

### design/rgb_packed_small_float_convert_unit.sv
// Converts between three single-precision color channels and a packed
// R11G11B10 unsigned small-float word (red bits 0-10, green 11-21, blue 22-31).
// Request channel: drive req_* and pulse start; a request is taken at an edge
// where start is high and busy is low. busy is always low, so a request can
// be issued every cycle.
// Response channel: rsp_valid is high for one cycle, in the cycle after the
// request was taken, with the result on the rsp_* ports. The receiver cannot
// stall; each result is taken at the edge ending its cycle.
// Throughput: one request per clock; the response comes from the single
// result register behind three parallel channel lanes.
// Reset clears rsp_valid; no request is lost or duplicated across reset
// other than those in flight, which are dropped.
module rgb_packed_small_float_convert_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_red_bits,
   input  logic [31:0] req_green_bits,
   input  logic [31:0] req_blue_bits,
   input  logic [31:0] req_packed_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_packed_out,
   output logic [31:0] rsp_red_out,
   output logic [31:0] rsp_green_out,
   output logic [31:0] rsp_blue_out
);

   logic [10:0] enc_r, enc_g, enc_b;
   logic [31:0] dec_r, dec_g, dec_b;
   rgbpk_pkg::result_type merged;
   rgbpk_pkg::result_type result_ff, result_in;
   logic valid_ff, valid_in;

   rgbpk_lane u_red (.narrow(1'b0), .single_bits(req_red_bits),
      .small_bits(req_packed_in[10:0]), .enc_bits(enc_r), .dec_bits(dec_r));
   rgbpk_lane u_green (.narrow(1'b0), .single_bits(req_green_bits),
      .small_bits(req_packed_in[21:11]), .enc_bits(enc_g), .dec_bits(dec_g));
   rgbpk_lane u_blue (.narrow(1'b1), .single_bits(req_blue_bits),
      .small_bits({1'b0, req_packed_in[31:22]}), .enc_bits(enc_b), .dec_bits(dec_b));

   rgbpk_merge u_merge (.kind(req_kind), .enc_r(enc_r), .enc_g(enc_g), .enc_b(enc_b),
      .dec_r(dec_r), .dec_g(dec_g), .dec_b(dec_b), .result(merged));

   assign busy      = 1'b0;
   assign valid_in  = start && !busy;
   assign result_in = valid_in ? merged : result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_packed_out = result_ff.packed_word;
   assign rsp_red_out    = result_ff.red;
   assign rsp_green_out  = result_ff.green;
   assign rsp_blue_out   = result_ff.blue;

endmodule

### design/rgbpk_lane.sv
// One color channel: encode single to small float, or decode back.
// narrow selects the 5-bit mantissa form (blue); otherwise 6 bits.
module rgbpk_lane (
   input  logic        narrow,
   input  logic [31:0] single_bits,
   input  logic [10:0] small_bits,
   output logic [10:0] enc_bits,
   output logic [31:0] dec_bits
);

   logic [7:0]  e8;
   logic [22:0] man;
   logic [5:0]  mmask;
   logic [4:0]  rebias;
   logic [4:0]  de;
   logic [5:0]  dm;
   logic [2:0]  p;
   logic [5:0]  rest;
   logic [7:0]  dexp;
   logic [22:0] dfrac;

   assign e8     = single_bits[30:23];
   assign man    = single_bits[22:0];
   assign mmask  = narrow ? 6'h1F : 6'h3F;
   assign rebias = 5'(e8 - 8'd112);

   always_comb begin
      if (single_bits[31]) begin
         enc_bits = '0;
      end else if (e8 > 8'd142) begin
         enc_bits = narrow ? {1'b0, 5'h1F, (e8 == 8'hFF) ? man[4:0] : 5'd0}
                           : {5'h1F, (e8 == 8'hFF) ? man[5:0] : 6'd0};
      end else if (e8 <= 8'd112) begin
         enc_bits = '0;
      end else begin
         enc_bits = narrow ? {1'b0, rebias, man[22:18]} : {rebias, man[22:17]};
      end
   end

   always_comb begin
      de = narrow ? small_bits[9:5] : small_bits[10:6];
      dm = small_bits[5:0] & mmask;
      p  = '0;
      for (int i = 1; i < 6; i++) begin
         if (dm[i]) p = 3'(i);
      end
      rest  = dm & ~(6'd1 << p);
      dexp  = 8'(8'd113 + {5'd0, p} - (narrow ? 8'd5 : 8'd6));
      dfrac = 23'({17'd0, rest} << (5'd23 - {2'd0, p}));
      if (de == '0) begin
         dec_bits = (dm == '0) ? 32'd0 : {1'b0, dexp, dfrac};
      end else if (de != 5'h1F) begin
         dec_bits = {1'b0, 8'({3'd0, de} + 8'd112),
                     narrow ? {dm[4:0], 18'd0} : {dm, 17'd0}};
      end else begin
         dec_bits = (dm == '0) ? rgbpk_pkg::SingleInf : rgbpk_pkg::SingleNan;
      end
   end

endmodule

### design/rgbpk_merge.sv
// Combine lane outputs into the result according to the mode.
module rgbpk_merge (
   input  logic                   kind,
   input  logic [10:0]            enc_r,
   input  logic [10:0]            enc_g,
   input  logic [10:0]            enc_b,
   input  logic [31:0]            dec_r,
   input  logic [31:0]            dec_g,
   input  logic [31:0]            dec_b,
   output rgbpk_pkg::result_type  result
);

   always_comb begin
      if (kind == rgbpk_pkg::KindPack) begin
         result.packed_word = {enc_b[9:0], enc_g, enc_r};
         result.red   = '0;
         result.green = '0;
         result.blue  = '0;
      end else begin
         result.packed_word = '0;
         result.red   = dec_r;
         result.green = dec_g;
         result.blue  = dec_b;
      end
   end

endmodule

### design/rgbpk_checker.sv
module rgbpk_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic [31:0] rsp_packed_out,
   input logic [31:0] rsp_red_out,
   input logic [31:0] rsp_green_out,
   input logic [31:0] rsp_blue_out
);

   a_one_per_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid) else $error("missing response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid) else $error("spurious response");

   a_pack_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_kind) |=>
      (rsp_red_out == 32'd0 && rsp_green_out == 32'd0 && rsp_blue_out == 32'd0))
      else $error("pack mode channels not zero");

   a_unpack_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind) |=> rsp_packed_out == 32'd0)
      else $error("unpack mode word not zero");

endmodule

bind rgb_packed_small_float_convert_unit rgbpk_checker u_rgbpk_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_kind(req_kind),
   .rsp_valid(rsp_valid), .rsp_packed_out(rsp_packed_out), .rsp_red_out(rsp_red_out),
   .rsp_green_out(rsp_green_out), .rsp_blue_out(rsp_blue_out));

### bench/rgb_packed_small_float_convert_unit_test.sv
`timescale 1ns / 100ps

module rgb_packed_small_float_convert_unit_test;

   typedef struct packed {
      logic        kind;
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
      logic [31:0] word;
   } request_type;

   typedef struct packed {
      logic [31:0] packed_word;
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_kind;
   logic [31:0] req_red_bits;
   logic [31:0] req_green_bits;
   logic [31:0] req_blue_bits;
   logic [31:0] req_packed_in;
   logic        rsp_valid;
   logic [31:0] rsp_packed_out;
   logic [31:0] rsp_red_out;
   logic [31:0] rsp_green_out;
   logic [31:0] rsp_blue_out;

   request_type pending_q[$];
   pixel_type   expected_q[$];
   int          error_count = 0;
   int          idle_percent = 21;

   rgb_packed_small_float_convert_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_red_bits(req_red_bits),
      .req_green_bits(req_green_bits), .req_blue_bits(req_blue_bits),
      .req_packed_in(req_packed_in), .rsp_valid(rsp_valid),
      .rsp_packed_out(rsp_packed_out), .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out), .rsp_blue_out(rsp_blue_out)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [31:0] encode_channel(logic [31:0] x, int mant_bits);
      logic [7:0]  e8;
      logic [31:0] mask;
      e8 = x[30:23];
      mask = (32'd1 << mant_bits) - 32'd1;
      if (x[31])
         return 32'd0;
      if (e8 > 8'd142)
         return (32'h1F << mant_bits) | ((e8 == 8'hFF) ? (x & mask) : 32'd0);
      if (e8 <= 8'd112)
         return 32'd0;
      return ((32'(e8) - 32'd112) << mant_bits) | ({9'd0, x[22:0]} >> (23 - mant_bits));
   endfunction

   function automatic logic [31:0] decode_channel(logic [31:0] v, int mant_bits);
      logic [31:0] mask;
      logic [31:0] e;
      logic [31:0] m;
      int          p;
      mask = (32'd1 << mant_bits) - 32'd1;
      e = (v >> mant_bits) & 32'h1F;
      m = v & mask;
      if (e == 0) begin
         if (m == 0)
            return 32'd0;
         // find the leading one and renormalize
         p = 0;
         while (p < mant_bits - 1 && (m >> (p + 1)) != 0)
            p++;
         return (32'(p + 113 - mant_bits) << 23) | ((m - (32'd1 << p)) << (23 - p));
      end
      if (e < 31)
         return ((e + 32'd112) << 23) | (m << (23 - mant_bits));
      return (m == 0) ? rgbpk_pkg::SingleInf : rgbpk_pkg::SingleNan;
   endfunction

   function automatic pixel_type convert_pixel(request_type r);
      pixel_type p;
      p = '0;
      if (r.kind == rgbpk_pkg::KindPack) begin
         p.packed_word = encode_channel(r.red, 6) | (encode_channel(r.green, 6) << 11)
                         | (encode_channel(r.blue, 5) << 22);
      end else begin
         p.red = decode_channel({21'd0, r.word[10:0]}, 6);
         p.green = decode_channel({21'd0, r.word[21:11]}, 6);
         p.blue = decode_channel({22'd0, r.word[31:22]}, 5);
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // driver: present the next request at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (pending_q.size() > 0 && $urandom_range(99) >= idle_percent) begin
         request_type r;
         r = pending_q.pop_front();
         start <= 1'b1;
         req_kind <= r.kind;
         req_red_bits <= r.red;
         req_green_bits <= r.green;
         req_blue_bits <= r.blue;
         req_packed_in <= r.word;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: predict on accepted requests, check responses
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("unexpected response at %0t", $time);
               error_count++;
            end else begin
               pixel_type w;
               w = expected_q.pop_front();
               if (rsp_packed_out !== w.packed_word)
                  report_mismatch("packed_out", rsp_packed_out, w.packed_word);
               if (rsp_red_out !== w.red)
                  report_mismatch("red_out", rsp_red_out, w.red);
               if (rsp_green_out !== w.green)
                  report_mismatch("green_out", rsp_green_out, w.green);
               if (rsp_blue_out !== w.blue)
                  report_mismatch("blue_out", rsp_blue_out, w.blue);
            end
         end
         if (start && !busy)
            expected_q.push_back(convert_pixel('{req_kind, req_red_bits, req_green_bits,
                                                 req_blue_bits, req_packed_in}));
      end
   end

   function automatic logic [31:0] random_single();
      logic [31:0] x;
      x = $urandom;
      case ($urandom_range(5))
         // bias exponent into the interesting window around the small-float range
         0, 1, 2: x[30:23] = 8'($urandom_range(100, 150));
         3: x[30:23] = 8'hFF;
         default: ;
      endcase
      if ($urandom_range(3) != 0)
         x[31] = 1'b0;
      return x;
   endfunction

   task automatic add_request(logic kind, logic [31:0] r, logic [31:0] g,
                              logic [31:0] b, logic [31:0] w);
      pending_q.push_back('{kind, r, g, b, w});
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_kind = rgbpk_pkg::KindPack;
      req_red_bits = '0;
      req_green_bits = '0;
      req_blue_bits = '0;
      req_packed_in = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_request(rgbpk_pkg::KindPack, 32'h0, 32'h8000_0000, 32'h3F80_0000, 32'h0);
      add_request(rgbpk_pkg::KindPack, 32'hFFC0_0001, 32'h3880_0000, 32'h3800_0000,
                  32'hFFFF_FFFF);
      add_request(rgbpk_pkg::KindPack, 32'h4780_0000, 32'h477F_FFFF, 32'h7F80_0000, 32'h0);
      add_request(rgbpk_pkg::KindPack, 32'h7FC0_0000, 32'h7F80_003F, 32'h7FFF_FFFF, 32'h0);
      add_request(rgbpk_pkg::KindPack, 32'h3880_0001, 32'h387F_FFFF, 32'h0000_0001, 32'h0);
      add_request(rgbpk_pkg::KindPack, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7F80_001F,
                  32'hFFFF_FFFF);
      add_request(rgbpk_pkg::KindUnpack, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h0);
      add_request(rgbpk_pkg::KindUnpack, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      add_request(rgbpk_pkg::KindUnpack, 32'h0, 32'h0, 32'h0,
                  {5'h1F, 5'h0, 5'h1F, 6'h0, 5'h1F, 6'h0});
      add_request(rgbpk_pkg::KindUnpack, 32'h0, 32'h0, 32'h0,
                  {10'h001, 11'h001, 11'h001});
      add_request(rgbpk_pkg::KindUnpack, 32'h0, 32'h0, 32'h0,
                  {10'h01F, 11'h03F, 11'h020});
      add_request(rgbpk_pkg::KindUnpack, 32'h0, 32'h0, 32'h0,
                  {10'h010, 11'h002, 11'h003});
      add_request(rgbpk_pkg::KindUnpack, 32'h0, 32'h0, 32'h0,
                  {10'h3DF, 11'h7BF, 11'h040});
      add_request(rgbpk_pkg::KindUnpack, 32'h0, 32'h0, 32'h0,
                  {10'h3E1, 11'h7C1, 11'h7FE});

      for (int phase = 0; phase < 3; phase++) begin
         idle_percent = (phase == 0) ? 21 : (phase == 1) ? 87 : 0;
         for (int n = 0; n < 633; n++) begin
            if ($urandom_range(1))
               add_request(rgbpk_pkg::KindPack, random_single(), random_single(),
                           random_single(), $urandom);
            else
               add_request(rgbpk_pkg::KindUnpack, $urandom, $urandom, $urandom, $urandom);
         end
         wait (pending_q.size() == 0 && expected_q.size() == 0);
         @(posedge clock);
      end
      repeat (5) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0)
         $display("rgb_packed_small_float_convert_unit test passed");
      else
         $display("rgb_packed_small_float_convert_unit test failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("rgb_packed_small_float_convert_unit test failed");
      $finish;
   end

endmodule

### sim.f
design/rgbpk_pkg.sv
design/rgbpk_lane.sv
design/rgbpk_merge.sv
design/rgb_packed_small_float_convert_unit.sv
design/rgbpk_checker.sv
bench/rgb_packed_small_float_convert_unit_test.sv
